/* hdl/ppa_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package ppa_pkg;

    localparam int NUM_PAGES = 32;
    localparam int PAGE_W    = $clog2(NUM_PAGES);
    localparam int COUNT_W   = $clog2(NUM_PAGES + 1);
    localparam int OWNER_W   = 9;
    localparam int HANDLE_W  = 32;

    localparam logic signed [OWNER_W-1:0] OWNER_NONE  = -9'sd1;
    localparam logic [HANDLE_W-1:0]       HANDLE_NONE = '0;

    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_NO_FREE = 1'b1;

    typedef enum logic [1:0] {
        FUNC_ALLOC  = 2'd0,
        FUNC_FREE   = 2'd1,
        FUNC_VICTIM = 2'd2,
        FUNC_LOOKUP = 2'd3
    } func_t;

    typedef struct packed {
        logic              found;
        logic [PAGE_W-1:0] page;
    } scan_status_t;

    typedef struct packed {
        logic                        en;
        logic [PAGE_W-1:0]           addr;
        logic signed [OWNER_W-1:0]   owner;
        logic [HANDLE_W-1:0]         handle;
    } table_wr_t;

endpackage

`default_nettype wire

/* hdl/ppa_req_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface ppa_req_if;

    logic                                 valid;
    logic                                 ready;
    ppa_pkg::func_t                       func;
    logic signed [ppa_pkg::OWNER_W-1:0]   owner_id;
    logic [ppa_pkg::HANDLE_W-1:0]         entry_handle;
    logic [ppa_pkg::PAGE_W-1:0]           page_number;

    modport source (
        output valid, func, owner_id, entry_handle, page_number,
        input  ready
    );

    modport sink (
        input  valid, func, owner_id, entry_handle, page_number,
        output ready
    );

endinterface

`default_nettype wire

/* hdl/ppa_rsp_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface ppa_rsp_if;

    logic                                 valid;
    logic                                 ready;
    logic                                 status;
    logic [ppa_pkg::PAGE_W-1:0]           page_out;
    logic signed [ppa_pkg::OWNER_W-1:0]   owner_out;
    logic [ppa_pkg::HANDLE_W-1:0]         handle_out;

    modport source (
        output valid, status, page_out, owner_out, handle_out,
        input  ready
    );

    modport sink (
        input  valid, status, page_out, owner_out, handle_out,
        output ready
    );

endinterface

`default_nettype wire

/* hdl/physical_page_allocator_top.sv */
// Physical page allocator for a pool of 32 pages.
// Requests arrive on req (valid/ready); each yields one transfer on rsp.
// req.func selects allocate, free, victim pick or lookup of owner and handle.
// Allocate walks the used-bit map one page per cycle from page 0 with a
// single shared scan unit; allocate with no free page, free and victim
// go straight to the finish state; lookup passes through a read state
// first (one registered table read). req.ready is high only while no
// request is in progress; after a result is handed to the output register
// the next request is taken the following cycle.
// The output register holds one result: if rsp stalls, a finished request
// waits in the finish state until the register frees and req stays low.
// A new request may be accepted while one result waits on rsp.
// Reset frees every page, sets the free count to 32, clears the victim
// pointer and marks every table entry as unset (owner -1, handle 0);
// the unset marks are flip-flops, so no clearing pass follows reset.
`timescale 1ns / 1ps
`default_nettype none

module physical_page_allocator_top (
    input  wire logic   clk,
    input  wire logic   rst_n,
    ppa_req_if.sink     req,
    ppa_rsp_if.source   rsp
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_READ,
        ST_FINISH
    } state_t;

    state_t                              state_reg;
    state_t                              state_next;
    logic [ppa_pkg::NUM_PAGES-1:0]       used_reg;
    logic [ppa_pkg::NUM_PAGES-1:0]       used_next;
    logic [ppa_pkg::COUNT_W-1:0]         free_count_reg;
    logic [ppa_pkg::COUNT_W-1:0]         free_count_next;
    logic [ppa_pkg::PAGE_W-1:0]          victim_reg;
    logic [ppa_pkg::PAGE_W-1:0]          victim_next;
    logic signed [ppa_pkg::OWNER_W-1:0]  req_owner_reg;
    logic signed [ppa_pkg::OWNER_W-1:0]  req_owner_next;
    logic [ppa_pkg::HANDLE_W-1:0]        req_handle_reg;
    logic [ppa_pkg::HANDLE_W-1:0]        req_handle_next;
    logic                                res_status_reg;
    logic                                res_status_next;
    logic [ppa_pkg::PAGE_W-1:0]          res_page_reg;
    logic [ppa_pkg::PAGE_W-1:0]          res_page_next;
    logic signed [ppa_pkg::OWNER_W-1:0]  res_owner_reg;
    logic signed [ppa_pkg::OWNER_W-1:0]  res_owner_next;
    logic [ppa_pkg::HANDLE_W-1:0]        res_handle_reg;
    logic [ppa_pkg::HANDLE_W-1:0]        res_handle_next;
    logic                                out_valid_reg;
    logic                                out_valid_next;
    logic                                out_status_reg;
    logic                                out_status_next;
    logic [ppa_pkg::PAGE_W-1:0]          out_page_reg;
    logic [ppa_pkg::PAGE_W-1:0]          out_page_next;
    logic signed [ppa_pkg::OWNER_W-1:0]  out_owner_reg;
    logic signed [ppa_pkg::OWNER_W-1:0]  out_owner_next;
    logic [ppa_pkg::HANDLE_W-1:0]        out_handle_reg;
    logic [ppa_pkg::HANDLE_W-1:0]        out_handle_next;

    logic                                in_xfer;
    logic                                slot_free;
    logic                                scan_start;
    ppa_pkg::scan_status_t               scan;
    ppa_pkg::table_wr_t                  tbl_wr;
    logic                                tbl_rd_en;
    logic signed [ppa_pkg::OWNER_W-1:0]  tbl_owner;
    logic [ppa_pkg::HANDLE_W-1:0]        tbl_handle;

    assign req.ready  = (state_reg == ST_IDLE);
    assign in_xfer    = req.valid && req.ready;
    assign slot_free  = !out_valid_reg || rsp.ready;
    assign scan_start = in_xfer && (req.func == ppa_pkg::FUNC_ALLOC) && (free_count_reg != '0);
    assign tbl_rd_en  = in_xfer && (req.func == ppa_pkg::FUNC_LOOKUP);

    assign tbl_wr.en     = (state_reg == ST_SCAN) && scan.found;
    assign tbl_wr.addr   = scan.page;
    assign tbl_wr.owner  = req_owner_reg;
    assign tbl_wr.handle = req_handle_reg;

    assign rsp.valid      = out_valid_reg;
    assign rsp.status     = out_status_reg;
    assign rsp.page_out   = out_page_reg;
    assign rsp.owner_out  = out_owner_reg;
    assign rsp.handle_out = out_handle_reg;

    ppa_scan u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (scan_start),
        .used_bits (used_reg),
        .scan      (scan)
    );

    ppa_table u_table (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr        (tbl_wr),
        .rd_en     (tbl_rd_en),
        .rd_addr   (req.page_number),
        .rd_owner  (tbl_owner),
        .rd_handle (tbl_handle)
    );

    always_comb
    begin
        state_next      = state_reg;
        used_next       = used_reg;
        free_count_next = free_count_reg;
        victim_next     = victim_reg;
        req_owner_next  = req_owner_reg;
        req_handle_next = req_handle_reg;
        res_status_next = res_status_reg;
        res_page_next   = res_page_reg;
        res_owner_next  = res_owner_reg;
        res_handle_next = res_handle_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_page_next   = out_page_reg;
        out_owner_next  = out_owner_reg;
        out_handle_next = out_handle_reg;

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    req_owner_next  = req.owner_id;
                    req_handle_next = req.entry_handle;
                    res_status_next = ppa_pkg::STATUS_OK;
                    res_page_next   = '0;
                    res_owner_next  = '0;
                    res_handle_next = '0;
                    unique case (req.func)
                        ppa_pkg::FUNC_ALLOC:
                        begin
                            if (free_count_reg != '0)
                            begin
                                state_next = ST_SCAN;
                            end
                            else
                            begin
                                res_status_next = ppa_pkg::STATUS_NO_FREE;
                                state_next      = ST_FINISH;
                            end
                        end
                        ppa_pkg::FUNC_FREE:
                        begin
                            if (used_reg[req.page_number])
                            begin
                                used_next[req.page_number] = 1'b0;
                                free_count_next            = free_count_reg + 1'b1;
                            end
                            state_next = ST_FINISH;
                        end
                        ppa_pkg::FUNC_VICTIM:
                        begin
                            res_page_next = victim_reg;
                            if (victim_reg == ppa_pkg::PAGE_W'(ppa_pkg::NUM_PAGES - 1))
                            begin
                                victim_next = '0;
                            end
                            else
                            begin
                                victim_next = victim_reg + 1'b1;
                            end
                            state_next = ST_FINISH;
                        end
                        ppa_pkg::FUNC_LOOKUP:
                        begin
                            res_page_next = req.page_number;
                            state_next    = ST_READ;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (scan.found)
                begin
                    used_next[scan.page] = 1'b1;
                    free_count_next      = free_count_reg - 1'b1;
                    res_page_next        = scan.page;
                    state_next           = ST_FINISH;
                end
            end
            ST_READ:
            begin
                res_owner_next  = tbl_owner;
                res_handle_next = tbl_handle;
                state_next      = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (slot_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_page_next   = res_page_reg;
                    out_owner_next  = res_owner_reg;
                    out_handle_next = res_handle_reg;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            used_reg       <= '0;
            free_count_reg <= ppa_pkg::COUNT_W'(ppa_pkg::NUM_PAGES);
            victim_reg     <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            used_reg       <= used_next;
            free_count_reg <= free_count_next;
            victim_reg     <= victim_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_owner_reg  <= req_owner_next;
        req_handle_reg <= req_handle_next;
        res_status_reg <= res_status_next;
        res_page_reg   <= res_page_next;
        res_owner_reg  <= res_owner_next;
        res_handle_reg <= res_handle_next;
        out_status_reg <= out_status_next;
        out_page_reg   <= out_page_next;
        out_owner_reg  <= out_owner_next;
        out_handle_reg <= out_handle_next;
    end

`ifndef ASSERT_OFF
    a_count_matches_map: assert property (@(posedge clk) disable iff (!rst_n)
        (ppa_pkg::COUNT_W'($countones(used_reg)) + free_count_reg)
            == ppa_pkg::COUNT_W'(ppa_pkg::NUM_PAGES))
        else $error("free count disagrees with used-bit map");

    a_scan_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (free_count_reg != '0))
        else $error("scan running with no free page");

    a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> !req.ready)
        else $error("request taken while previous request in progress");

    a_found_is_free: assert property (@(posedge clk) disable iff (!rst_n)
        tbl_wr.en |=> used_reg[$past(scan.page)])
        else $error("allocated page not marked used");
`endif

endmodule

`default_nettype wire

/* hdl/ppa_scan.sv */
`timescale 1ns / 1ps
`default_nettype none

module ppa_scan (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    input  wire logic [ppa_pkg::NUM_PAGES-1:0]     used_bits,
    output ppa_pkg::scan_status_t                  scan
);

    logic                        active_reg;
    logic                        active_next;
    logic [ppa_pkg::PAGE_W-1:0]  idx_reg;
    logic [ppa_pkg::PAGE_W-1:0]  idx_next;
    logic                        hit;

    assign hit        = active_reg && !used_bits[idx_reg];
    assign scan.found = hit;
    assign scan.page  = idx_reg;

    always_comb
    begin
        active_next = active_reg;
        idx_next    = idx_reg;
        if (start)
        begin
            active_next = 1'b1;
            idx_next    = '0;
        end
        else if (active_reg)
        begin
            if (hit)
            begin
                active_next = 1'b0;
            end
            else
            begin
                idx_next = idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            idx_reg    <= '0;
        end
        else
        begin
            active_reg <= active_next;
            idx_reg    <= idx_next;
        end
    end

endmodule

`default_nettype wire

/* hdl/ppa_table.sv */
`timescale 1ns / 1ps
`default_nettype none

module ppa_table (
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    input  wire ppa_pkg::table_wr_t                      wr,
    input  wire logic                                    rd_en,
    input  wire logic [ppa_pkg::PAGE_W-1:0]              rd_addr,
    output logic signed [ppa_pkg::OWNER_W-1:0]           rd_owner,
    output logic [ppa_pkg::HANDLE_W-1:0]                 rd_handle
);

    logic signed [ppa_pkg::OWNER_W-1:0]  owner_mem  [ppa_pkg::NUM_PAGES];
    logic [ppa_pkg::HANDLE_W-1:0]        handle_mem [ppa_pkg::NUM_PAGES];
    logic [ppa_pkg::NUM_PAGES-1:0]       valid_reg;
    logic signed [ppa_pkg::OWNER_W-1:0]  rd_owner_reg;
    logic [ppa_pkg::HANDLE_W-1:0]        rd_handle_reg;

    assign rd_owner  = rd_owner_reg;
    assign rd_handle = rd_handle_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr.en)
        begin
            valid_reg[wr.addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            owner_mem[wr.addr]  <= wr.owner;
            handle_mem[wr.addr] <= wr.handle;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            if (valid_reg[rd_addr])
            begin
                rd_owner_reg  <= owner_mem[rd_addr];
                rd_handle_reg <= handle_mem[rd_addr];
            end
            else
            begin
                rd_owner_reg  <= ppa_pkg::OWNER_NONE;
                rd_handle_reg <= ppa_pkg::HANDLE_NONE;
            end
        end
    end

endmodule

`default_nettype wire
